// ===== rtl/audio_spike_jitter_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// audio spike jitter filter - assertion macros
// shared concurrent check forms, sampled on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef AUDIO_SPIKE_JITTER_FILTER_CORE_MACROS_SVH
`define AUDIO_SPIKE_JITTER_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define ASJF_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASJF_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/asjf_pkg.sv =====
// ----------------------------------------------------------------------------
// asjf_pkg
// types, constants and byte helpers shared by the spike jitter filter
// ----------------------------------------------------------------------------
`default_nettype none

package asjf_pkg;

    localparam int WIN_CELLS = 4;          // window cells, index 3 newest
    localparam int PUSH_MAX  = 3;          // results one frame can cause
    localparam int Q_DEPTH   = 4;          // result queue entries

    localparam logic [2:0] SEEN_FULL    = 3'd4;
    localparam logic [7:0] THRESH_RESET = 8'd8;

    typedef logic [31:0]       t_frame;    // right in 31:16, left in 15:0
    typedef logic signed [7:0] t_sbyte;
    typedef logic [1:0]        t_chmask;   // bit 0 left, bit 1 right

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        lfix;
        logic        rfix;
        logic        bend;
    } t_res;

    // signed high byte of one channel
    function automatic t_sbyte hi_byte(input t_frame f, input logic ch);
        return ch ? f[31:24] : f[15:8];
    endfunction

    // replace the high bytes selected by fix
    function automatic t_frame patch_hi(input t_frame f, input t_chmask fix,
                                        input t_sbyte repl_l, input t_sbyte repl_r);
        t_frame o;
        o = f;
        if (fix[0]) begin
            o[15:8] = repl_l;
        end
        if (fix[1]) begin
            o[31:24] = repl_r;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/asjf_cell.sv =====
// ----------------------------------------------------------------------------
// asjf_cell
// one window slot: takes its input frame on each shift, patching high bytes
// ----------------------------------------------------------------------------
`default_nettype none

module asjf_cell import asjf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_shift,
    input  t_frame     i_frame,
    input  t_chmask    i_fix,
    input  t_sbyte     i_repl_l,
    input  t_sbyte     i_repl_r,
    output t_frame     o_frame,
    output t_sbyte     o_hi_l,
    output t_sbyte     o_hi_r
);

    t_frame r_frame;
    t_frame n_frame;

    assign n_frame = patch_hi(i_frame, i_fix, i_repl_l, i_repl_r);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame = r_frame;
    assign o_hi_l  = hi_byte(r_frame, 1'b0);
    assign o_hi_r  = hi_byte(r_frame, 1'b1);

endmodule

`default_nettype wire

// ===== rtl/asjf_spike.sv =====
// ----------------------------------------------------------------------------
// asjf_spike
// five-tap spike decision for one channel and its replacement byte
// ----------------------------------------------------------------------------
`default_nettype none

module asjf_spike import asjf_pkg::*; (
    input  t_sbyte     i_a,        // x[k-2]
    input  t_sbyte     i_l,        // x[k-1]
    input  t_sbyte     i_m,        // x[k]
    input  t_sbyte     i_r,        // x[k+1]
    input  t_sbyte     i_e,        // x[k+2]
    input  wire [7:0]  i_thresh,
    output logic       o_spike,
    output t_sbyte     o_repl
);

    typedef logic signed [8:0] t_s9;

    function automatic t_s9 sx(input t_sbyte v);
        return t_s9'(v);
    endfunction

    function automatic logic slope_ok(input t_s9 hll, input t_s9 hr, input t_s9 hl);
        logic pos;
        logic neg;
        pos = (hll > 0) && (((hr > 0) && (hr < hll)) || ((hl > 0) && (hl < hll)));
        neg = (hll < 0) && (((hr < 0) && (hr > hll)) || ((hl < 0) && (hl > hll)));
        return pos || neg;
    endfunction

    t_s9        hr, hl, hll_a, hll_e, sum, adj;
    logic [8:0] abs_hr, abs_hl;
    logic       big_r, big_l, between;

    assign hr     = sx(i_m) - sx(i_r);
    assign hl     = sx(i_l) - sx(i_m);
    assign abs_hr = hr[8] ? 9'(-hr) : 9'(hr);
    assign abs_hl = hl[8] ? 9'(-hl) : 9'(hl);
    assign big_r  = abs_hr > {1'b0, i_thresh};
    assign big_l  = abs_hl > {1'b0, i_thresh};

    assign between = ((i_l < i_m) && (i_m < i_r)) || ((i_r < i_m) && (i_m < i_l));

    assign hll_a = sx(i_a) - sx(i_r);
    assign hll_e = sx(i_l) - sx(i_e);

    assign o_spike = big_r && big_l && !between
                   && !slope_ok(hll_a, hr, hl) && !slope_ok(hll_e, hr, hl);

    // halve toward zero: bump negative sums by one before the shift
    assign sum    = sx(i_l) + sx(i_r);
    assign adj    = sum + t_s9'({8'd0, sum[8]});
    assign o_repl = adj[8:1];

endmodule

`default_nettype wire

// ===== rtl/asjf_outq.sv =====
// ----------------------------------------------------------------------------
// asjf_outq
// compacting result queue, up to three pushes and one pop per beat
// ----------------------------------------------------------------------------
`default_nettype none

module asjf_outq import asjf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire [1:0]  i_push_cnt,
    input  t_res       i_push [PUSH_MAX],
    output logic       o_room,
    output logic       o_valid,
    output t_res       o_res,
    input  wire        i_ready,
    output logic [2:0] o_level
);

    t_res       r_q [Q_DEPTH];
    t_res       n_q [Q_DEPTH];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [2:0] base;
    logic [2:0] off;
    logic       pop;

    assign pop  = (r_cnt != 3'd0) && i_ready;
    assign base = r_cnt - {2'd0, pop};

    always_comb begin
        off = 3'd0;
        for (int j = 0; j < Q_DEPTH; j++) begin
            if (pop && (j < Q_DEPTH - 1)) begin
                n_q[j] = r_q[(j + 1) % Q_DEPTH];
            end else begin
                n_q[j] = r_q[j];
            end
            off = 3'(j) - base;
            if ((3'(j) >= base) && (off < {1'b0, i_push_cnt})) begin
                n_q[j] = i_push[off[1:0]];
            end
        end
        n_cnt = base + {1'b0, i_push_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < Q_DEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

    // room for a full burst even if nothing drains this beat
    assign o_room  = r_cnt <= 3'(Q_DEPTH - PUSH_MAX);
    assign o_valid = r_cnt != 3'd0;
    assign o_res   = r_q[0];
    assign o_level = r_cnt;

endmodule

`default_nettype wire

// ===== rtl/audio_spike_jitter_filter_core.sv =====
// ----------------------------------------------------------------------------
// audio_spike_jitter_filter_core
// stereo spike filter on signed high bytes, two-frame delay, flush on last
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+----------------------------------
//  in      | i_in_valid / o_in_ready      | i_left_sample i_right_sample i_last
//  out     | o_out_valid / i_out_ready    | o_left_out o_right_out o_left_fixed
//          |                              | o_right_fixed o_block_end
//  cfg     | i_cfg_valid / o_cfg_ready    | i_delta_threshold
//
//  one frame per clock while the queue has room; the five-tap decision is
//  combinational, feeding the window chain; results go to a four-entry queue
//  a closing frame can queue three beats, so input stalls while the queue
//  holds more than one beat; output stalls only back up into that queue
//  synchronous active-low reset: empty window, empty queue, threshold 8
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_spike_jitter_filter_core_macros.svh"

module audio_spike_jitter_filter_core import asjf_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // frame input
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire signed [15:0] i_left_sample,
    input  wire signed [15:0] i_right_sample,
    input  wire               i_last,
    // result output
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [15:0] o_left_out,
    output logic signed [15:0] o_right_out,
    output logic              o_left_fixed,
    output logic              o_right_fixed,
    output logic              o_block_end,
    // threshold write
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [7:0]         i_delta_threshold
);

    // control state
    logic [2:0] r_seen;        // frames in current block, saturating at 4
    logic [2:0] n_seen;
    logic [7:0] r_thresh;

    logic   in_acc;
    t_frame cur;

    // window chain, cell 3 newest
    t_frame  win   [WIN_CELLS];
    t_frame  feed  [WIN_CELLS];
    t_chmask fix_in[WIN_CELLS];
    t_sbyte  hi_l  [WIN_CELLS];
    t_sbyte  hi_r  [WIN_CELLS];

    // decision
    logic    test_on;
    logic    spike_l, spike_r;
    t_sbyte  repl_l, repl_r;
    t_chmask fix_mid;
    t_frame  mid_fixed;

    // results of this beat
    t_res       push [PUSH_MAX];
    logic [1:0] k;
    logic [1:0] push_cnt;
    logic [2:0] q_level;

    assign in_acc = i_in_valid && o_in_ready;
    assign cur    = {i_right_sample, i_left_sample};

    // ---- threshold register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_delta_threshold;
        end
    end

    // ---- spike test on the middle cell once the window is full
    assign test_on = r_seen == SEEN_FULL;

    asjf_spike u_spike_l (
        .i_a      (hi_l[0]),
        .i_l      (hi_l[1]),
        .i_m      (hi_l[2]),
        .i_r      (hi_l[3]),
        .i_e      (hi_byte(cur, 1'b0)),
        .i_thresh (r_thresh),
        .o_spike  (spike_l),
        .o_repl   (repl_l)
    );

    asjf_spike u_spike_r (
        .i_a      (hi_r[0]),
        .i_l      (hi_r[1]),
        .i_m      (hi_r[2]),
        .i_r      (hi_r[3]),
        .i_e      (hi_byte(cur, 1'b1)),
        .i_thresh (r_thresh),
        .o_spike  (spike_r),
        .o_repl   (repl_r)
    );

    assign fix_mid   = test_on ? {spike_r, spike_l} : 2'b00;
    assign mid_fixed = patch_hi(win[2], fix_mid, repl_l, repl_r);

    // ---- window chain: each accepted beat shifts the input in at cell 3;
    // the corrected middle frame lands in cell 1 so later decisions see it
    genvar gi;
    generate
        for (gi = 0; gi < WIN_CELLS; gi++) begin : g_cell
            if (gi == WIN_CELLS - 1) begin : g_head
                assign feed[gi] = cur;
            end else begin : g_body
                assign feed[gi] = win[gi + 1];
            end
            assign fix_in[gi] = (gi == 1) ? fix_mid : 2'b00;

            asjf_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (in_acc),
                .i_frame  (feed[gi]),
                .i_fix    (fix_in[gi]),
                .i_repl_l (repl_l),
                .i_repl_r (repl_r),
                .o_frame  (win[gi]),
                .o_hi_l   (hi_l[gi]),
                .o_hi_r   (hi_r[gi])
            );
        end
    endgenerate

    // ---- frame count; a closing frame restarts the block
    always_comb begin
        if (i_last) begin
            n_seen = 3'd0;
        end else if (r_seen == SEEN_FULL) begin
            n_seen = SEEN_FULL;
        end else begin
            n_seen = r_seen + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 3'd0;
        end else if (in_acc) begin
            r_seen <= n_seen;
        end
    end

    // ---- results of this beat, in order:
    // delayed middle frame, then on last the held frame and the current one
    always_comb begin
        for (int j = 0; j < PUSH_MAX; j++) begin
            push[j] = '0;
        end
        k = 2'd0;
        if (r_seen >= 3'd2) begin
            push[k] = '{left: mid_fixed[15:0], right: mid_fixed[31:16],
                        lfix: fix_mid[0], rfix: fix_mid[1], bend: 1'b0};
            k = k + 2'd1;
        end
        if (i_last) begin
            if (r_seen != 3'd0) begin
                push[k] = '{left: win[3][15:0], right: win[3][31:16],
                            lfix: 1'b0, rfix: 1'b0, bend: 1'b0};
                k = k + 2'd1;
            end
            push[k] = '{left: cur[15:0], right: cur[31:16],
                        lfix: 1'b0, rfix: 1'b0, bend: 1'b1};
            k = k + 2'd1;
        end
    end

    assign push_cnt = in_acc ? k : 2'd0;

    // ---- result queue, its head is the output register
    t_res head;

    asjf_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push     (push),
        .o_room     (o_in_ready),
        .o_valid    (o_out_valid),
        .o_res      (head),
        .i_ready    (i_out_ready),
        .o_level    (q_level)
    );

    assign o_left_out    = head.left;
    assign o_right_out   = head.right;
    assign o_left_fixed  = head.lfix;
    assign o_right_fixed = head.rfix;
    assign o_block_end   = head.bend;

    // ---- checks
    `ASJF_CHECK(a_level_bound, 1'b1, q_level <= 3'(Q_DEPTH),
        "result queue over its depth")
    `ASJF_CHECK_NEXT(a_block_restart, in_acc && i_last, r_seen == 3'd0,
        "frame count not cleared after closing frame")
    `ASJF_CHECK_NEXT(a_mid_queued, in_acc && !i_last && (r_seen >= 3'd2), o_out_valid,
        "delayed frame not queued")
    `ASJF_CHECK(a_fixed_not_end, o_out_valid && (o_left_fixed || o_right_fixed),
        !o_block_end, "corrected beat marked as block end")

endmodule

`default_nettype wire
